/* sv/tacm_pkg.sv */
package tacm_pkg;

	localparam int RAW_BITS_DEF   = 12;
	localparam int FRAC_BITS_DEF  = 24;
	localparam int COORD_BITS_DEF = 16;
	localparam int COEF_BITS      = 48;
	localparam int LIMIT_BITS     = 16;
	localparam int PROD_BITS      = 64;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_SOLVE = 2'd1;
	localparam logic [1:0] OP_MAP   = 2'd2;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [1:0]  pair_slot;
		logic [11:0] touch_raw_x;
		logic [11:0] touch_raw_y;
		logic [15:0] target_screen_x;
		logic [15:0] target_screen_y;
	} tacm_in_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic        solve_status;
		logic        map_valid;
		logic [15:0] mapped_x;
		logic [15:0] mapped_y;
	} tacm_out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DET, ST_NUM, ST_DIV, ST_DIVW, ST_MAP, ST_MAPW, ST_OUT
	} tacm_state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} tacm_ctl_t;

endpackage

/* sv/tacm_mul.sv */
// shift-add multiplier, one bit of b per cycle, signed operands
module tacm_mul #(
	parameter int W = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic                busy,
	output logic signed [W-1:0] p
);
	import tacm_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  acc_q, a_q, b_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;

	// wrapping product mod 2^W, exact when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CW'(W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (run_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = run_q | start;
	assign p    = acc_q;
endmodule

/* sv/tacm_div.sv */
// restoring divider, one quotient bit per cycle, rounded and saturated to coef range
module tacm_div #(
	parameter int FRAC = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [63:0]   num,
	input  logic signed [63:0]   den,
	output logic                 busy,
	output logic signed [47:0]   q
);
	import tacm_pkg::*;

	// dividend n << (FRAC+1) needs 64+FRAC+1 bits
	localparam int NW = 64 + FRAC + 1;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q, quo_q;
	logic [64:0]   r_q;
	logic [63:0]   d_q;
	logic          neg_q, run_q;
	logic [CW-1:0] cnt_q;
	logic [64:0]   r_sh;
	logic [NW-1:0] qr;
	logic [NW-1:0] lim;

	assign r_sh = {r_q[63:0], n_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CW'(NW);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[63] ^ den[63];
			n_q   <= NW'(num[63] ? 64'(-num) : 64'(num)) << (FRAC + 1);
			d_q   <= den[63] ? 64'(-den) : 64'(den);
			r_q   <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			n_q <= n_q << 1;
			if (r_sh >= {1'b0, d_q}) begin
				r_q   <= r_sh - {1'b0, d_q};
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				r_q   <= r_sh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// quotient has one extra bit: round half away from zero
	always_comb begin
		qr  = (quo_q >> 1) + NW'(quo_q[0]);
		lim = neg_q ? NW'(48'h800000000000) : NW'(48'h7FFFFFFFFFFF);
		if (qr > lim) begin
			qr = lim;
		end
		q = neg_q ? 48'(-qr[47:0]) : qr[47:0];
	end

	assign busy = run_q | start;
endmodule

/* sv/touch_affine_calibrate_map_core.sv */
// from request to result valid: load and opcode three go straight to the output state;
// map runs four products, a degenerate solve four, a full solve forty and six quotients;
// each product runs on the bit-serial multiplier (64-bit words), each quotient on the
// bit-serial divider; one request at a time, the next request can be taken in the cycle
// after the result is accepted
// reset: identity map, zero pairs, limits 480 and 320, solved flag clear (map_valid low until a solve)
module touch_affine_calibrate_map_core #(
	parameter int FRAC_BITS = tacm_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tacm_pkg::tacm_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tacm_pkg::tacm_out_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import tacm_pkg::*;

	tacm_state_t state_q, state_d;
	tacm_in_t    req_q;
	tacm_out_t   res_q;
	logic [15:0] wlim_q, hlim_q;
	logic        solved_q;
	logic [11:0] prx_q [3];
	logic [11:0] pry_q [3];
	logic [15:0] psx_q [3];
	logic [15:0] psy_q [3];
	logic signed [47:0] coef_q [6];
	logic signed [47:0] ncoef_q [6];

	// microprogram of products: acc op= mA * mB
	logic [5:0]  step_q;
	logic signed [63:0] acc_q, det_q, t_q, u_q;
	logic signed [63:0] num_q [6];
	logic [2:0]  didx_q;
	logic        mstart, dstart;
	logic        mbusy, dbusy;
	logic signed [63:0] ma, mb, mp;
	logic signed [47:0] dq;
	tacm_ctl_t   mctl;

	logic signed [63:0] x0, y0, x1, y1, x2, y2, s0, s1, s2;
	logic               jsel;

	assign jsel = step_q >= 6'd22;
	assign x0 = 64'(prx_q[0]);
	assign y0 = 64'(pry_q[0]);
	assign x1 = 64'(prx_q[1]);
	assign y1 = 64'(pry_q[1]);
	assign x2 = 64'(prx_q[2]);
	assign y2 = 64'(pry_q[2]);
	assign s0 = 64'(jsel ? psy_q[0] : psx_q[0]);
	assign s1 = 64'(jsel ? psy_q[1] : psx_q[1]);
	assign s2 = 64'(jsel ? psy_q[2] : psx_q[2]);

	// op: 0 acc=p, 1 acc+=p, 2 acc-=p; also t/u temporaries
	logic [1:0] op_c;
	logic [2:0] dst_c;
	logic [4:0] ls;
	assign ls = jsel ? 5'(step_q - 6'd22) : 5'(step_q - 6'd4);

	always_comb begin
		ma = '0; mb = '0; op_c = 2'd0; dst_c = 3'd0;
		if (step_q < 6'd4) begin
			unique case (step_q[1:0])
				2'd0: begin ma = x0; mb = y1 - y2; op_c = 2'd0; end
				2'd1: begin ma = y0; mb = x1 - x2; op_c = 2'd2; end
				2'd2: begin ma = x1; mb = y2; op_c = 2'd1; end
				default: begin ma = x2; mb = y1; op_c = 2'd2; end
			endcase
		end else begin
			// ls 0..3 t0, 4..7 t1, 8..9 t=y1*s2-y2*s1, 10..11 u=x1*s2-x2*s1,
			// 12..13 u=x0*t-y0*u, 14..15 t=x1*y2-x2*y1, 16..17 t2=s0*t+u
			case (ls)
				5'd0:  begin ma = s0; mb = y1 - y2; op_c = 2'd0; end
				5'd1:  begin ma = y0; mb = s1 - s2; op_c = 2'd2; end
				5'd2:  begin ma = s1; mb = y2; op_c = 2'd1; end
				5'd3:  begin ma = s2; mb = y1; op_c = 2'd2; dst_c = 3'd1; end
				5'd4:  begin ma = x0; mb = s1 - s2; op_c = 2'd0; end
				5'd5:  begin ma = s0; mb = x1 - x2; op_c = 2'd2; end
				5'd6:  begin ma = x1; mb = s2; op_c = 2'd1; end
				5'd7:  begin ma = x2; mb = s1; op_c = 2'd2; dst_c = 3'd2; end
				5'd8:  begin ma = y1; mb = s2; op_c = 2'd0; end
				5'd9:  begin ma = y2; mb = s1; op_c = 2'd2; dst_c = 3'd4; end
				5'd10: begin ma = x1; mb = s2; op_c = 2'd0; end
				5'd11: begin ma = x2; mb = s1; op_c = 2'd2; dst_c = 3'd5; end
				5'd12: begin ma = x0; mb = t_q; op_c = 2'd0; end
				5'd13: begin ma = y0; mb = u_q; op_c = 2'd2; dst_c = 3'd5; end
				5'd14: begin ma = x1; mb = y2; op_c = 2'd0; end
				5'd15: begin ma = x2; mb = y1; op_c = 2'd2; dst_c = 3'd4; end
				5'd16: begin ma = s0; mb = t_q; op_c = 2'd0; end
				default: begin ma = u_q; mb = 64'sd1; op_c = 2'd1; dst_c = 3'd3; end
			endcase
		end
	end

	// map products: per coordinate k0*x, k1*y then saturating sums
	logic [1:0] mstep_q;
	logic       mcoord_q;
	logic signed [63:0] sum_q;
	logic signed [63:0] mapa, mapb;

	assign mapa = 64'(coef_q[{mcoord_q, 1'b0} + {1'b0, mcoord_q} + 3'(mstep_q)]);
	assign mapb = mstep_q[0] ? 64'(req_q.touch_raw_y) : 64'(req_q.touch_raw_x);

	assign mctl.start = mstart;
	assign mctl.busy  = mbusy;

	tacm_mul #(.W(PROD_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mctl.start),
		.a(state_q == ST_MAP || state_q == ST_MAPW ? mapa : ma),
		.b(state_q == ST_MAP || state_q == ST_MAPW ? mapb : mb),
		.busy(mbusy), .p(mp)
	);

	tacm_div #(.FRAC(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart),
		.num(num_q[didx_q]), .den(det_q),
		.busy(dbusy), .q(dq)
	);

	// saturating add of 64-bit signed values
	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (!a[63] && !b[63] && s[63]) begin
			s = 64'h7FFFFFFFFFFFFFFF;
		end else if (a[63] && b[63] && !s[63]) begin
			s = 64'sh8000000000000000;
		end
		return s;
	endfunction

	// final clamp of one coordinate
	function automatic logic [15:0] clampc(input logic signed [63:0] s,
			input logic [15:0] lim);
		logic [63:0] v;
		v = 64'($unsigned(s) >> FRAC_BITS);
		if (lim == 16'd0 || s[63]) begin
			return 16'd0;
		end
		if (v >= 64'(lim)) begin
			return lim - 16'd1;
		end
		return v[15:0];
	endfunction

	logic mrun_q;
	logic mdone;
	assign mdone = mrun_q && !mbusy;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		mstart  = 1'b0;
		dstart  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.opcode == OP_SOLVE) begin
						state_d = ST_DET;
					end else if (in_data.opcode == OP_MAP) begin
						state_d = ST_MAP;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_DET, ST_NUM: begin
				if (!mrun_q) begin
					mstart = 1'b1;
				end else if (mdone) begin
					if (step_q == 6'd3) begin
						state_d = (sadd(acc_q, -mp) == 64'sd0) ? ST_OUT : ST_NUM;
					end else if (step_q == 6'd39) begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				dstart  = 1'b1;
				state_d = ST_DIVW;
			end
			ST_DIVW: begin
				if (!dbusy) begin
					state_d = (didx_q == 3'd5) ? ST_OUT : ST_DIV;
				end
			end
			ST_MAP: begin
				if (!mrun_q) begin
					mstart = 1'b1;
				end else if (mdone && mstep_q == 2'd1 && mcoord_q) begin
					state_d = ST_MAPW;
				end
			end
			ST_MAPW: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid) begin
					state_d = ST_OUT;
				end else if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;

	logic out_v_q;
	assign out_valid = out_v_q;
	assign out_data  = res_q;

	logic signed [63:0] accn;
	always_comb begin
		case (op_c)
			2'd0: accn = mp;
			2'd1: accn = acc_q + mp;
			2'd2: accn = acc_q - mp;
			default: accn = acc_q + mp;
		endcase
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlim_q   <= 16'd480;
			hlim_q   <= 16'd320;
			solved_q <= 1'b0;
			out_v_q  <= 1'b0;
			mrun_q   <= 1'b0;
			step_q   <= '0;
			mstep_q  <= '0;
			mcoord_q <= 1'b0;
			didx_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				prx_q[i] <= '0; pry_q[i] <= '0; psx_q[i] <= '0; psy_q[i] <= '0;
			end
			for (int i = 0; i < 6; i++) begin
				coef_q[i] <= (i == 0 || i == 4) ? (48'sd1 <<< FRAC_BITS) : 48'sd0;
			end
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_WIDTH) begin
					wlim_q <= cfg_data;
				end else begin
					hlim_q <= cfg_data;
				end
			end
			if (mstart) begin
				mrun_q <= 1'b1;
			end else if (mdone) begin
				mrun_q <= 1'b0;
			end
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0; mstep_q <= '0; mcoord_q <= 1'b0; didx_q <= '0;
					if (in_valid) begin
						req_q <= in_data;
						res_q <= '{result_kind: in_data.opcode, solve_status: 1'b0,
							map_valid: solved_q, mapped_x: 16'd0, mapped_y: 16'd0};
						if (in_data.opcode == OP_LOAD && in_data.pair_slot != 2'd3) begin
							prx_q[in_data.pair_slot] <= in_data.touch_raw_x;
							pry_q[in_data.pair_slot] <= in_data.touch_raw_y;
							psx_q[in_data.pair_slot] <= in_data.target_screen_x;
							psy_q[in_data.pair_slot] <= in_data.target_screen_y;
						end
						if (in_data.opcode != OP_SOLVE && in_data.opcode != OP_MAP) begin
							out_v_q <= 1'b1;
						end
					end
				end
				ST_DET, ST_NUM: begin
					if (mdone) begin
						acc_q  <= accn;
						step_q <= step_q + 6'd1;
						if (step_q == 6'd3) begin
							det_q <= accn;
							if (accn == 64'sd0) begin
								res_q.solve_status <= 1'b1;
								out_v_q <= 1'b1;
							end
						end else begin
							case (dst_c)
								3'd1: num_q[jsel ? 3'd3 : 3'd0] <= accn;
								3'd2: num_q[jsel ? 3'd4 : 3'd1] <= accn;
								3'd3: num_q[jsel ? 3'd5 : 3'd2] <= accn;
								3'd4: t_q <= accn;
								3'd5: u_q <= accn;
								default: ;
							endcase
						end
					end
				end
				ST_DIVW: begin
					if (!dbusy) begin
						ncoef_q[didx_q] <= dq;
						didx_q <= didx_q + 3'd1;
						if (didx_q == 3'd5) begin
							for (int i = 0; i < 5; i++) begin
								coef_q[i] <= ncoef_q[i];
							end
							coef_q[5] <= dq;
							solved_q  <= 1'b1;
							res_q.map_valid <= 1'b1;
							out_v_q <= 1'b1;
						end
					end
				end
				ST_MAP: begin
					if (mdone) begin
						if (mstep_q == 2'd0) begin
							mstep_q <= 2'd1;
							sum_q   <= mp;
						end else begin
							mstep_q  <= 2'd0;
							mcoord_q <= 1'b1;
							if (!mcoord_q) begin
								res_q.mapped_x <= clampc(sadd(sadd(sum_q, mp),
									64'(coef_q[2])), wlim_q);
							end else begin
								res_q.mapped_y <= clampc(sadd(sadd(sum_q, mp),
									64'(coef_q[5])), hlim_q);
							end
						end
					end
				end
				ST_MAPW: begin
					out_v_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_in_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !out_valid)
		else $error("request taken while result pending");
	a_out_in_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == ST_OUT))
		else $error("result valid outside output state");
	a_solved_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(solved_q) |-> solved_q)
		else $error("solved flag dropped");
`endif
endmodule
